FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// assert that antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

FILE: sv/irtlp_pkg.sv
// ----------------------------------------------------------------------------
// irtlp_pkg
// Types, constants and functions of the logistic response probability block.
// ----------------------------------------------------------------------------
package irtlp_pkg;
   localparam int MAX_DIMS = 4;
   localparam int ITEM_COUNT = 256;
   localparam int ITEM_W = 8;
   localparam int VAL_W = 16;
   localparam int PROD_W = 32;
   localparam int ETA_W = 35;
   localparam int MAG_W = ETA_W - 12;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   localparam logic [1:0] REG_MODEL_ORDER = 2'd0;
   localparam logic [1:0] REG_DIMS_IN_USE = 2'd1;
   localparam logic [1:0] REG_LOWER_BOUND = 2'd2;
   localparam logic [1:0] REG_UPPER_BOUND = 2'd3;

   localparam logic [1:0] ORDER_UNIT = 2'd1;
   localparam logic [1:0] ORDER_SLOPE = 2'd2;
   localparam logic [1:0] ORDER_GUESS = 2'd3;

   typedef struct packed {
      logic       func;
      logic [7:0] item_index;
      logic signed [15:0] guess_value;
      logic signed [15:0] ability_a;
      logic signed [15:0] ability_b;
      logic signed [15:0] ability_c;
      logic signed [15:0] ability_d;
      logic signed [15:0] slope_a;
      logic signed [15:0] slope_b;
      logic signed [15:0] slope_c;
      logic signed [15:0] slope_d;
      logic signed [15:0] intercept;
   } req_type;

   typedef struct packed {
      logic [15:0] probability;
      logic [7:0]  item_echo;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  model_order;
      logic [2:0]  dims_in_use;
      logic [15:0] lower_bound;
      logic [15:0] upper_bound;
   } cfg_type;

   function automatic logic [16:0] sig_sample(input logic [4:0] i);
      logic [16:0] r;
      case (i)
         5'd0: r = 17'd32768;  5'd1: r = 17'd40793;  5'd2: r = 17'd47911;
         5'd3: r = 17'd53581;  5'd4: r = 17'd57724;  5'd5: r = 17'd60565;
         5'd6: r = 17'd62428;  5'd7: r = 17'd63615;  5'd8: r = 17'd64357;
         5'd9: r = 17'd64816;  5'd10: r = 17'd65097; 5'd11: r = 17'd65269;
         5'd12: r = 17'd65374; 5'd13: r = 17'd65438; 5'd14: r = 17'd65476;
         5'd15: r = 17'd65500;
         default: r = 17'd65514;
      endcase
      return r;
   endfunction

   // logistic of a Q12 sign-magnitude value, Q0.16 result (17 bits)
   function automatic logic [16:0] logistic(input logic neg, input logic [MAG_W-1:0] mag);
      logic [16:0] lo;
      logic [16:0] hi;
      logic [27:0] step;
      logic [16:0] pos;
      lo = sig_sample(mag[15:11]);
      hi = sig_sample(mag[15:11] + 5'd1);
      step = 28'((hi - lo) * 28'(mag[10:0]));
      if (mag[MAG_W-1:15] != '0) pos = 17'd65514;
      else pos = lo + 17'(step >> 11);
      return neg ? 17'(17'd65536 - pos) : pos;
   endfunction
endpackage

FILE: sv/irtlp_stream_if.sv
// ----------------------------------------------------------------------------
// irtlp_stream_if
// Valid/ready channel carrying one payload type.
// ----------------------------------------------------------------------------
interface irtlp_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: sv/irtlp_ram.sv
// ----------------------------------------------------------------------------
// irtlp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module irtlp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: sv/irtlp_lane.sv
// ----------------------------------------------------------------------------
// irtlp_lane
// One dimension: registered product of slope (or unit slope) and ability, masked when unused.
// ----------------------------------------------------------------------------
module irtlp_lane (
   input  logic                                clock,
   input  logic                                advance,
   input  logic                                enable,
   input  logic                                unit_slope,
   input  logic signed [irtlp_pkg::VAL_W-1:0]  ability,
   input  logic signed [irtlp_pkg::VAL_W-1:0]  slope,
   output logic signed [irtlp_pkg::PROD_W-1:0] product
);
   logic signed [irtlp_pkg::VAL_W-1:0]  slope_eff;
   logic signed [irtlp_pkg::PROD_W-1:0] product_in;
   logic signed [irtlp_pkg::PROD_W-1:0] product_ff;

   always_comb begin
      slope_eff = unit_slope ? 16'sd4096 : slope;
      if (enable) product_in = ability * slope_eff;
      else product_in = '0;
   end

   always_ff @(posedge clock) begin
      if (advance) product_ff <= product_in;
   end
   assign product = product_ff;
endmodule

FILE: sv/irtlp_merge.sv
// ----------------------------------------------------------------------------
// irtlp_merge
// Sum lane products and intercept, then logistic, guessing floor and clamp.
// ----------------------------------------------------------------------------
module irtlp_merge (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [irtlp_pkg::PROD_W-1:0] products [irtlp_pkg::MAX_DIMS],
   input  logic signed [irtlp_pkg::VAL_W-1:0]  intercept,
   input  logic                                use_guess,
   input  logic [irtlp_pkg::VAL_W-1:0]         guess_raw,
   input  irtlp_pkg::cfg_type                  cfg,
   output logic [15:0]                         probability
);
   logic signed [irtlp_pkg::ETA_W-1:0] eta;
   logic [irtlp_pkg::ETA_W-1:0]        eta_abs;
   logic [16:0]                        lg_in;
   logic [16:0]                        gq_in;
   logic                               guess_mid;
   logic [16:0]                        lg_ff;
   logic [16:0]                        gq_ff;
   logic                               use_guess_ff;
   logic [33:0]                        mix;
   logic [17:0]                        p;
   logic signed [15:0]                 g;

   always_comb begin
      eta = irtlp_pkg::ETA_W'(intercept) <<< 12;
      for (int i = 0; i < irtlp_pkg::MAX_DIMS; i++)
         eta = eta + irtlp_pkg::ETA_W'(products[i]);
      eta_abs = eta[irtlp_pkg::ETA_W-1] ? irtlp_pkg::ETA_W'(-eta) : irtlp_pkg::ETA_W'(eta);
      lg_in = irtlp_pkg::logistic(eta[irtlp_pkg::ETA_W-1],
                                  eta_abs[irtlp_pkg::ETA_W-1:12]);
      g = guess_raw;
      guess_mid = !g[15] && (g <= 16'sd4096);
      if (guess_mid)
         gq_in = {g[12:0], 4'd0};
      else
         gq_in = irtlp_pkg::logistic(g[15],
                                     irtlp_pkg::MAG_W'(g[15] ? 16'(-g) : 16'(g)));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lg_ff <= lg_in;
         gq_ff <= gq_in;
         use_guess_ff <= use_guess;
      end
   end

   always_comb begin
      mix = 34'(17'd65536 - gq_ff) * 34'(lg_ff);
      p = use_guess_ff ? 18'(gq_ff) + 18'(mix >> 16) : 18'(lg_ff);
      if (p < 18'(cfg.lower_bound)) p = 18'(cfg.lower_bound);
      if (p > 18'(cfg.upper_bound)) p = 18'(cfg.upper_bound);
      probability = p[15:0];
   end
endmodule

FILE: sv/irt_logistic_response_probability.sv
// ----------------------------------------------------------------------------
// irt_logistic_response_probability
// Multidimensional logistic item response probability with guessing floor.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_ (valid/ready, one transaction each). A load
// transaction (func 0) writes a guess entry and returns nothing; an evaluate
// transaction (func 1) returns one rsp_ transaction with the clamped
// probability and the echoed item index. The user must write configuration
// via csr_we/csr_index/csr_wdata only while idle; the block does not enforce
// this. Throughput: one transaction per cycle unless the output stalls. Three
// register stages (lane multiply and guess RAM read, logistic, mixing and
// clamp into the output register); rsp_valid comes from the last of the
// valid registers s1, s2 and s3. Four multiplier lanes work in parallel and
// the merge stage sums them. Reset clears the pipeline valid bits and loads
// the register defaults; the guess table is not cleared. When the receiver
// stalls, the whole pipeline holds and req_ready drops until the output
// register is taken.
// ----------------------------------------------------------------------------
module irt_logistic_response_probability (
   input  logic        clock,
   input  logic        reset,
   irtlp_stream_if.sink   req_,
   irtlp_stream_if.source rsp_,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
`include "assert_macros.svh"
   irtlp_pkg::cfg_type cfg_ff;
   logic               advance;
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [7:0]         s1_item_ff, s2_item_ff;
   logic               s1_guess_ff;
   logic signed [15:0] s1_intercept_ff;
   logic signed [irtlp_pkg::PROD_W-1:0] products [irtlp_pkg::MAX_DIMS];
   logic [15:0]        guess_rd;
   logic [15:0]        prob;
   irtlp_pkg::rsp_type rsp_ff;
   logic [2:0]         dims;
   logic               unit;
   logic               accept;
   logic               eval;
   logic signed [15:0] abil [irtlp_pkg::MAX_DIMS];
   logic signed [15:0] slp [irtlp_pkg::MAX_DIMS];

   assign advance = !s3_valid_ff || rsp_.ready;
   assign req_.ready = advance;
   assign accept = req_.valid && advance;
   assign eval = req_.data.func == irtlp_pkg::FUNC_EVAL;
   assign dims = (cfg_ff.dims_in_use > 3'd4) ? 3'd4 : cfg_ff.dims_in_use;
   assign unit = cfg_ff.model_order == irtlp_pkg::ORDER_UNIT;
   assign abil = '{req_.data.ability_a, req_.data.ability_b,
                   req_.data.ability_c, req_.data.ability_d};
   assign slp = '{req_.data.slope_a, req_.data.slope_b,
                  req_.data.slope_c, req_.data.slope_d};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{model_order: irtlp_pkg::ORDER_GUESS, dims_in_use: 3'd4,
                     lower_bound: 16'd1, upper_bound: 16'd65534};
      end else if (csr_we) begin
         case (csr_index)
            irtlp_pkg::REG_MODEL_ORDER: cfg_ff.model_order <= csr_wdata[1:0];
            irtlp_pkg::REG_DIMS_IN_USE: cfg_ff.dims_in_use <= csr_wdata[2:0];
            irtlp_pkg::REG_LOWER_BOUND: cfg_ff.lower_bound <= csr_wdata;
            irtlp_pkg::REG_UPPER_BOUND: cfg_ff.upper_bound <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < irtlp_pkg::MAX_DIMS; i++) begin : g_lane
      irtlp_lane u_lane (
         .clock(clock), .advance(advance), .enable(3'(i) < dims),
         .unit_slope(unit), .ability(abil[i]), .slope(slp[i]),
         .product(products[i]));
   end

   irtlp_ram #(.WIDTH(16), .DEPTH(irtlp_pkg::ITEM_COUNT)) u_guess (
      .clock(clock), .wr_en(accept && !eval), .wr_addr(req_.data.item_index),
      .wr_data(req_.data.guess_value), .rd_en(advance),
      .rd_addr(req_.data.item_index), .rd_data(guess_rd));

   irtlp_merge u_merge (
      .clock(clock), .advance(advance), .products(products),
      .intercept(s1_intercept_ff), .use_guess(s1_guess_ff),
      .guess_raw(guess_rd), .cfg(cfg_ff), .probability(prob));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && eval;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s1_item_ff <= req_.data.item_index;
         s1_intercept_ff <= req_.data.intercept;
         s1_guess_ff <= !(cfg_ff.model_order == irtlp_pkg::ORDER_UNIT ||
                          cfg_ff.model_order == irtlp_pkg::ORDER_SLOPE);
         s2_item_ff <= s1_item_ff;
         rsp_ff <= '{probability: prob, item_echo: s2_item_ff};
      end
   end

   assign rsp_.valid = s3_valid_ff;
   assign rsp_.data = rsp_ff;

   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_.valid && !rsp_.ready, rsp_.valid,
                "result lost while stalled")
   `ASSERT_IMPL(a_ready_free, clock, reset, !rsp_.valid, req_.ready,
                "input blocked with empty output")
   `ASSERT_NEXT(a_load_silent, clock, reset, accept && !eval, !s1_valid_ff,
                "load produced a result")
endmodule

FILE: test/irt_logistic_response_probability_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irt_logistic_response_probability_tb
// Drives load and evaluate transactions through the logistic response block
// under random idling on both channels and across several register settings,
// and checks every response against an independent fixed point predictor.
// ----------------------------------------------------------------------------
module irt_logistic_response_probability_tb;

   localparam logic [1:0] ORDER_ZERO = 2'd0;

   class response_scoreboard;
      irtlp_pkg::rsp_type expected_rsp[$];
      logic [15:0] guess_mem[256];
      logic [1:0]  order;
      logic [2:0]  dims;
      logic [15:0] lo_bound;
      logic [15:0] hi_bound;
      int          fails;

      function new();
         order = irtlp_pkg::ORDER_GUESS;
         dims = 3'd4;
         lo_bound = 16'd1;
         hi_bound = 16'd65534;
         fails = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            irtlp_pkg::REG_MODEL_ORDER: order = val[1:0];
            irtlp_pkg::REG_DIMS_IN_USE: dims = val[2:0];
            irtlp_pkg::REG_LOWER_BOUND: lo_bound = val;
            default: hi_bound = val;
         endcase
      endfunction

      function longint sigmoid_q16(bit neg, longint mag);
         longint samples[17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428,
            63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};
         longint idx;
         longint pos;
         idx = mag >> 11;
         if (idx >= 16) pos = samples[16];
         else pos = samples[idx] +
            (((samples[idx+1] - samples[idx]) * (mag & 2047)) >> 11);
         return neg ? 65536 - pos : pos;
      endfunction

      function void note_request(irtlp_pkg::req_type r);
         longint eta;
         longint mag;
         longint lg;
         longint g;
         longint gq;
         longint p;
         int     nd;
         longint ab[4];
         longint sl[4];
         irtlp_pkg::rsp_type e;
         if (r.func == irtlp_pkg::FUNC_LOAD) begin
            guess_mem[r.item_index] = r.guess_value;
            return;
         end
         ab = '{r.ability_a, r.ability_b, r.ability_c, r.ability_d};
         sl = '{r.slope_a, r.slope_b, r.slope_c, r.slope_d};
         nd = dims > 4 ? 4 : dims;
         eta = longint'(r.intercept) * 4096;
         for (int j = 0; j < nd; j++)
            eta += (order == irtlp_pkg::ORDER_UNIT) ? ab[j] * 4096 : ab[j] * sl[j];
         mag = (eta < 0 ? -eta : eta) >> 12;
         lg = sigmoid_q16(eta < 0, mag);
         if (order == irtlp_pkg::ORDER_UNIT || order == irtlp_pkg::ORDER_SLOPE) p = lg;
         else begin
            g = longint'($signed(guess_mem[r.item_index]));
            if (g < 0 || g > 4096) gq = sigmoid_q16(g < 0, g < 0 ? -g : g);
            else gq = g * 16;
            p = gq + (((65536 - gq) * lg) >> 16);
         end
         if (p < lo_bound) p = lo_bound;
         if (p > hi_bound) p = hi_bound;
         e.probability = p[15:0];
         e.item_echo = r.item_index;
         expected_rsp.push_back(e);
      endfunction

      function void check_response(irtlp_pkg::rsp_type a);
         irtlp_pkg::rsp_type e;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response prob=%0d item=%0d", $time,
               a.probability, a.item_echo);
            fails++;
            return;
         end
         e = expected_rsp.pop_front();
         if (a.probability !== e.probability) begin
            $display("%0t: probability expected %0d actual %0d", $time,
               e.probability, a.probability);
            fails++;
         end
         if (a.item_echo !== e.item_echo) begin
            $display("%0t: item_echo expected %0d actual %0d", $time,
               e.item_echo, a.item_echo);
            fails++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   bit          calm;
   bit          written[256];
   byte unsigned loaded_items[$];
   response_scoreboard sb;

   irtlp_stream_if #(.payload_type(irtlp_pkg::req_type)) req_ch ();
   irtlp_stream_if #(.payload_type(irtlp_pkg::rsp_type)) rsp_ch ();

   irt_logistic_response_probability dut (
      .clock(clock), .reset(reset), .req_(req_ch), .rsp_(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
      rsp_ch.ready <= calm || $urandom_range(99) >= 19;
   end

   function automatic logic [15:0] pick_value();
      case ($urandom_range(9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3, 4: return 16'($urandom);
         default: return 16'($signed($urandom_range(8192)) - 4096);
      endcase
   endfunction

   function automatic irtlp_pkg::req_type make_eval(bit guessing);
      irtlp_pkg::req_type r;
      r.func = irtlp_pkg::FUNC_EVAL;
      r.item_index = guessing ? loaded_items[$urandom_range(loaded_items.size()-1)]
                              : 8'($urandom);
      r.guess_value = 16'($urandom);
      r.ability_a = pick_value();
      r.ability_b = pick_value();
      r.ability_c = pick_value();
      r.ability_d = pick_value();
      r.slope_a = pick_value();
      r.slope_b = pick_value();
      r.slope_c = pick_value();
      r.slope_d = pick_value();
      r.intercept = pick_value();
      return r;
   endfunction

   function automatic irtlp_pkg::req_type make_load(logic [7:0] idx, logic [15:0] g);
      irtlp_pkg::req_type r;
      r = irtlp_pkg::req_type'($urandom);
      r.ability_a = 16'($urandom);
      r.slope_d = 16'($urandom);
      r.intercept = 16'($urandom);
      r.func = irtlp_pkg::FUNC_LOAD;
      r.item_index = idx;
      r.guess_value = g;
      return r;
   endfunction

   task automatic send_request(irtlp_pkg::req_type r);
      int gap;
      gap = calm ? 0 : ($urandom_range(99) < 19 ? $urandom_range(1, 4) : 0);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_request(r);
      if (r.func == irtlp_pkg::FUNC_LOAD && !written[r.item_index]) begin
         written[r.item_index] = 1'b1;
         loaded_items.push_back(r.item_index);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic apply_setting(logic [1:0] ord, logic [2:0] nd,
                                logic [15:0] lo, logic [15:0] hi);
      drain();
      write_reg(irtlp_pkg::REG_MODEL_ORDER, {14'($urandom), ord});
      write_reg(irtlp_pkg::REG_DIMS_IN_USE, {13'($urandom), nd});
      write_reg(irtlp_pkg::REG_LOWER_BOUND, lo);
      write_reg(irtlp_pkg::REG_UPPER_BOUND, hi);
      csr_we <= 1'b0;
   endtask

   initial begin
      irtlp_pkg::req_type r;
      logic [15:0] guesses[8] = '{16'd0, 16'd4096, 16'd4097, 16'hffff,
                                  16'h7fff, 16'h8000, 16'd2048, 16'hf000};
      logic [1:0]  orders[8] = '{irtlp_pkg::ORDER_UNIT, irtlp_pkg::ORDER_SLOPE,
                                 irtlp_pkg::ORDER_GUESS, ORDER_ZERO,
                                 irtlp_pkg::ORDER_GUESS, irtlp_pkg::ORDER_SLOPE,
                                 ORDER_ZERO, irtlp_pkg::ORDER_UNIT};
      logic [2:0]  dim_set[8] = '{3'd0, 3'd1, 3'd4, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6};
      logic [15:0] lows[8] = '{16'd0, 16'd1, 16'd65535, 16'd0, 16'd30000,
                               16'd100, 16'd0, 16'd40000};
      logic [15:0] highs[8] = '{16'd65535, 16'd65534, 16'd65535, 16'd0, 16'd20000,
                                16'd65000, 16'd32768, 16'd65535};
      bit guessing;
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      calm = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: guess extremes, then evaluates at field extremes
      for (int i = 0; i < 8; i++) send_request(make_load(8'(i), guesses[i]));
      send_request(make_load(8'd255, 16'd4096));
      for (int i = 0; i < 9; i++) begin
         r = make_eval(1'b1);
         r.item_index = (i == 8) ? 8'd255 : 8'(i);
         send_request(r);
      end
      r = make_eval(1'b1);
      {r.ability_a, r.ability_b, r.ability_c, r.ability_d} = {4{16'h7fff}};
      {r.slope_a, r.slope_b, r.slope_c, r.slope_d, r.intercept} = {5{16'h7fff}};
      send_request(r);
      {r.slope_a, r.slope_b, r.slope_c, r.slope_d, r.intercept} = {5{16'h8000}};
      send_request(r);
      {r.ability_a, r.ability_b, r.ability_c, r.ability_d} = {4{16'h8000}};
      send_request(r);
      r = make_eval(1'b1);
      {r.ability_a, r.ability_b, r.ability_c, r.ability_d} = '0;
      {r.slope_a, r.slope_b, r.slope_c, r.slope_d, r.intercept} = '0;
      send_request(r);

      for (int ph = 0; ph < 8; ph++) begin
         apply_setting(orders[ph], dim_set[ph], lows[ph], highs[ph]);
         guessing = orders[ph] == irtlp_pkg::ORDER_GUESS || orders[ph] == ORDER_ZERO;
         calm = (ph == 2);
         for (int n = 0; n < 190; n++) begin
            if ($urandom_range(99) < 20)
               send_request(make_load(8'($urandom),
                  $urandom_range(1) ? 16'($urandom_range(4096)) : 16'($urandom)));
            else send_request(make_eval(guessing));
         end
      end
      calm = 1'b0;
      apply_setting(irtlp_pkg::ORDER_GUESS, 3'd4, 16'd1, 16'd65534);
      drain();
      if (sb.fails == 0 && sb.expected_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
